// ===== rtl/irle_pkg.sv =====
// ----------------------------------------------------------------------------
// irle_pkg
// Shared types and constants for the input run-length encoder.
// ----------------------------------------------------------------------------
package irle_pkg;

    // Run store geometry
    localparam int STORE_DEPTH = 4096;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int IDXW        = 12;
    localparam int WORDW       = 32;
    localparam int CMPW        = ((AW > IDXW) ? AW : IDXW) + 1;

    // Result queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Command codes
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_RECORD = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [IDXW-1:0]   read_index;
        logic              recording_blocked;
        logic              button_r;
        logic              button_z;
        logic              button_b;
        logic              button_a;
        logic signed [7:0] stick_y;
        logic signed [7:0] stick_x;
        logic [1:0]        cmd;
    } t_item;

    typedef struct packed {
        logic [WORDW-1:0] word;
        logic [IDXW-1:0]  word_index;
        logic             new_word;
        logic             cannot_save;
    } t_res;

endpackage

// ===== rtl/irle_ram.sv =====
// ----------------------------------------------------------------------------
// irle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module irle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/irle_front.sv =====
// ----------------------------------------------------------------------------
// irle_front
// Accepts frames and commands, keeps the current run word in flops, writes
// the run store and issues store reads. One registered stage aligns read
// data with the result before it goes to the queue.
// ----------------------------------------------------------------------------
module irle_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  irle_pkg::t_item         i_item,
    input  logic [irle_pkg::QAW:0]  i_q_level,
    output logic                    o_res_valid,
    output irle_pkg::t_res          o_res
);
    import irle_pkg::*;

    logic [AW-1:0]    r_cur_idx,  n_cur_idx;
    logic             r_empty,    n_empty;
    logic             r_failed,   n_failed;
    logic [WORDW-1:0] r_cur_word, n_cur_word;
    logic             r_s1_valid;
    logic             r_s1_read;
    t_res             r_s1;
    t_res             n_res;

    logic             acc;
    logic [QAW:0]     used;
    logic [WORDW-1:0] frame_word;
    logic             same_run;
    logic             at_last;
    logic             rd_ok;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [WORDW-1:0] wdata;
    logic             re;
    logic [WORDW-1:0] rdata;

    // Room is checked against queue level plus the beat in the stage
    assign used    = i_q_level + {{QAW{1'b0}}, r_s1_valid};
    assign o_ready = (used < (QAW+1)'(QDEPTH));
    assign acc     = i_valid && o_ready;

    assign frame_word = {i_item.button_a, i_item.button_b, i_item.button_z, i_item.button_r,
                         4'b0000, 8'h00, i_item.stick_y, i_item.stick_x};
    assign same_run   = ({r_cur_word[31:24], r_cur_word[15:0]} ==
                         {frame_word[31:24], frame_word[15:0]})
                        && (r_cur_word[23:16] != COUNT_MAX);
    assign at_last    = (r_cur_idx == AW'(STORE_DEPTH - 1));
    assign rd_ok      = (CMPW'(i_item.read_index) < CMPW'(STORE_DEPTH));

    always_comb begin
        n_cur_idx   = r_cur_idx;
        n_empty     = r_empty;
        n_failed    = r_failed;
        n_cur_word  = r_cur_word;
        we          = 1'b0;
        waddr       = r_cur_idx;
        wdata       = frame_word;
        re          = 1'b0;
        n_res.word        = '0;
        n_res.word_index  = IDXW'(r_cur_idx);
        n_res.new_word    = 1'b0;
        n_res.cannot_save = r_failed;
        unique case (i_item.cmd)
            CMD_START: begin
                n_cur_idx = '0;
                n_empty   = 1'b1;
                n_failed  = 1'b0;
                n_res.word_index  = '0;
                n_res.cannot_save = 1'b0;
            end
            CMD_RECORD: begin
                priority if (i_item.recording_blocked) begin
                    n_failed = 1'b1;
                    n_res.cannot_save = 1'b1;
                end else if (r_empty) begin
                    we         = 1'b1;
                    n_empty    = 1'b0;
                    n_cur_word = frame_word;
                    n_res.word     = frame_word;
                    n_res.new_word = 1'b1;
                end else if (same_run) begin
                    we         = 1'b1;
                    wdata      = {r_cur_word[31:24], r_cur_word[23:16] + 8'd1,
                                  r_cur_word[15:0]};
                    n_cur_word = wdata;
                    n_res.word = wdata;
                end else if (at_last) begin
                    // store full: frame dropped
                    n_failed = 1'b1;
                    n_res.cannot_save = 1'b1;
                end else begin
                    we         = 1'b1;
                    waddr      = r_cur_idx + AW'(1);
                    n_cur_idx  = waddr;
                    n_cur_word = frame_word;
                    n_res.word       = frame_word;
                    n_res.word_index = IDXW'(waddr);
                    n_res.new_word   = 1'b1;
                end
            end
            CMD_READ: begin
                re = rd_ok;
                n_res.word_index = i_item.read_index;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_idx  <= '0;
            r_empty    <= 1'b1;
            r_failed   <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc;
            if (acc) begin
                r_cur_idx <= n_cur_idx;
                r_empty   <= n_empty;
                r_failed  <= n_failed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_cur_word <= n_cur_word;
            r_s1       <= n_res;
            r_s1_read  <= re;
        end
    end

    irle_ram #(
        .WIDTH (WORDW),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (acc && we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (acc && re),
        .i_raddr (AW'(i_item.read_index)),
        .o_rdata (rdata)
    );

    always_comb begin
        o_res = r_s1;
        if (r_s1_read) begin
            o_res.word = rdata;
        end
    end
    assign o_res_valid = r_s1_valid;

`ifndef SYNTHESIS
    a_start_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_item.cmd == CMD_START) |=> (r_empty && !r_failed && r_cur_idx == '0))
        else $error("start did not empty the store");
    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_failed && !(acc && i_item.cmd == CMD_START)) |=> r_failed)
        else $error("cannot-save flag cleared without start");
    a_read_no_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_read) |-> !r_s1.new_word)
        else $error("read result flagged as new word");
`endif

endmodule

// ===== rtl/irle_fifo.sv =====
// ----------------------------------------------------------------------------
// irle_fifo
// Small result queue between the front and the output stage.
// ----------------------------------------------------------------------------
module irle_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  irle_pkg::t_res         i_data,
    input  logic                   i_pop,
    output logic                   o_nonempty,
    output irle_pkg::t_res         o_data,
    output logic [irle_pkg::QAW:0] o_level
);
    import irle_pkg::*;

    t_res           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QAW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QAW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QAW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QAW+1)'(1);
                2'b01:   r_count <= r_count - (QAW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data     = r_mem[r_rptr];
    assign o_nonempty = (r_count != '0);
    assign o_level    = r_count;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < (QAW+1)'(QDEPTH) || i_pop))
        else $error("result queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nonempty)
        else $error("result queue underflow");
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("result queue level out of range");
`endif

endmodule

// ===== rtl/irle_back.sv =====
// ----------------------------------------------------------------------------
// irle_back
// Output register: pops the result queue and holds a beat until taken.
// ----------------------------------------------------------------------------
module irle_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_nonempty,
    input  irle_pkg::t_res i_data,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output irle_pkg::t_res o_data
);
    import irle_pkg::*;

    logic r_valid;
    t_res r_data;

    assign o_pop = i_nonempty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/input_run_length_encoder_top.sv =====
// ----------------------------------------------------------------------------
// input_run_length_encoder_top
// Run-length recorder of controller frames into a 4096-word store.
// ----------------------------------------------------------------------------
// Each beat in gives exactly one beat out, in order. Command 0 starts a new
// recording (cannot-save cleared, old words kept), command 1 records a frame,
// command 2 reads a stored word, command 3 is a no-op. A frame matching the
// current word bumps its repeat count (bits 23:16) until 255; otherwise a new
// word opens at the next index. Blocked frames, or frames needing a word past
// the last entry, are dropped and set the sticky cannot-save flag. The current
// word lives in flops, so recording never waits on a store read: the block
// takes one beat per clock, sustained, while the result queue has room. A
// beat passes from input accept to output valid through the front stage
// with registered store read, the result queue and the output register.
// The store is a 4096 x 32 RAM with no clearing pass after reset; reading
// an entry never written returns undefined data.
// A four-entry result queue lets input keep flowing while output stalls.
// ----------------------------------------------------------------------------
module input_run_length_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] stick_x, [15:8] stick_y, [16] button_a, [17] button_b,
    // [18] button_z, [19] button_r, [20] recording_blocked,
    // [32:21] read_index, [39:33] zero
    input  logic [39:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] word, [43:32] word_index, [47:44] zero
    output logic [47:0] m_axis_tdata,
    // [0] new_word, [1] cannot_save
    output logic [1:0]  m_axis_tuser
);
    import irle_pkg::*;

    t_item        item;
    t_res         front_res;
    logic         front_valid;
    logic [QAW:0] q_level;
    logic         q_nonempty;
    t_res         q_data;
    logic         q_pop;
    t_res         out_res;

    // Unpack the input beat
    assign item.cmd               = s_axis_tuser;
    assign item.stick_x           = s_axis_tdata[7:0];
    assign item.stick_y           = s_axis_tdata[15:8];
    assign item.button_a          = s_axis_tdata[16];
    assign item.button_b          = s_axis_tdata[17];
    assign item.button_z          = s_axis_tdata[18];
    assign item.button_r          = s_axis_tdata[19];
    assign item.recording_blocked = s_axis_tdata[20];
    assign item.read_index        = s_axis_tdata[32:21];

    // Front: classify, update run state, access the store
    irle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_item      (item),
        .i_q_level   (q_level),
        .o_res_valid (front_valid),
        .o_res       (front_res)
    );

    // Queue: front only issues a beat when a slot is reserved for it
    irle_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (front_valid),
        .i_data     (front_res),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_data     (q_data),
        .o_level    (q_level)
    );

    // Back: output register
    irle_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (q_nonempty),
        .i_data     (q_data),
        .o_pop      (q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (out_res)
    );

    assign m_axis_tdata = {4'b0000, out_res.word_index, out_res.word};
    assign m_axis_tuser = {out_res.cannot_save, out_res.new_word};

endmodule
